FILE: rtl/core/mfsp_pkg.sv
`default_nettype none

package mfsp_pkg;

    typedef enum logic [3:0] {
        PH_HDR_MAGIC  = 4'd0,
        PH_HDR_LEN    = 4'd1,
        PH_HDR_FORMAT = 4'd2,
        PH_HDR_TRACKS = 4'd3,
        PH_HDR_DIV    = 4'd4,
        PH_TRK_MAGIC  = 4'd5,
        PH_TRK_LEN    = 4'd6,
        PH_DELTA      = 4'd7,
        PH_STATUS     = 4'd8,
        PH_META_TYPE  = 4'd9,
        PH_META_LEN   = 4'd10,
        PH_TEMPO      = 4'd11,
        PH_SKIP       = 4'd12,
        PH_NOTE_NUM   = 4'd13,
        PH_NOTE_VEL   = 4'd14,
        PH_DONE       = 4'd15
    } t_phase;

    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_DELAY    = 3'd1;
    localparam logic [2:0] KIND_NOTE_OFF = 3'd2;
    localparam logic [2:0] KIND_NOTE_ON  = 3'd3;
    localparam logic [2:0] KIND_TEMPO    = 3'd4;
    localparam logic [2:0] KIND_ERROR    = 3'd5;

    localparam logic [31:0] ERR_HEADER = 32'd0;
    localparam logic [31:0] ERR_TRACK  = 32'd1;
    localparam logic [31:0] ERR_EVENT  = 32'd2;

    localparam logic [31:0] MAGIC_HEADER = 32'h4D54_6864;
    localparam logic [31:0] MAGIC_TRACK  = 32'h4D54_726B;

    localparam logic [7:0] STATUS_META = 8'hFF;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [3:0] HI_NOTE_OFF = 4'h8;
    localparam logic [3:0] HI_NOTE_ON  = 4'h9;
    localparam logic [3:0] HI_POLY_AT  = 4'hA;
    localparam logic [3:0] HI_CONTROL  = 4'hB;
    localparam logic [3:0] HI_PROGRAM  = 4'hC;
    localparam logic [3:0] HI_CHAN_AT  = 4'hD;
    localparam logic [3:0] HI_PITCH    = 4'hE;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  channel;
        logic [7:0]  note;
        logic [7:0]  velocity;
        logic [31:0] value;
        logic [15:0] track_count;
    } t_out_item;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  field_byte_count;
        logic [31:0] accumulator;
        logic [31:0] chunk_remaining;
        logic [15:0] tracks_left;
        logic [7:0]  status_byte;
        logic [7:0]  first_data_byte;
        logic [7:0]  meta_type;
        logic [7:0]  meta_remaining;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:            PH_HDR_MAGIC,
        field_byte_count: 8'd0,
        accumulator:      32'd0,
        chunk_remaining:  32'd0,
        tracks_left:      16'd0,
        status_byte:      8'd0,
        first_data_byte:  8'd0,
        meta_type:        8'd0,
        meta_remaining:   8'd0
    };

endpackage

`default_nettype wire

FILE: rtl/core/midi_file_stream_parser.sv
`default_nettype none

// Streaming Standard MIDI File parser. One file byte is taken per request and
// each byte gives zero or one result: header (division and track count),
// nonzero delta delay, note on/off, tempo, or an error code for bad chunk
// magic or an unknown status byte; parsing carries on after an error and
// running status is not supported. Every byte is handled combinationally:
// the parse state and the result register are updated on the accepting edge,
// so one byte per cycle is sustained while the output does not stall, and a
// result appears on the output in the cycle after its byte is taken. The input
// is ready whenever the result register is empty or being drained. Raise
// start_of_file on the first byte of a file to restart at the header magic.
module midi_file_stream_parser (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire mfsp_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output mfsp_pkg::t_out_item     o_out_data
);

    mfsp_pkg::t_state    r_state;
    mfsp_pkg::t_state    n_state;
    logic                r_out_valid;
    mfsp_pkg::t_out_item r_out_data;
    logic                step_emit;
    mfsp_pkg::t_out_item step_result;
    logic                accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    mfsp_step u_step (
        .i_state  (r_state),
        .i_item   (i_in_data),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfsp_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= step_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && step_emit) begin
            r_out_data <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    a_drain_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && !(accept && step_emit)) |=> !r_out_valid)
        else $error("result still valid after being taken");

    a_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.start_of_file) |=>
        (r_state.phase == mfsp_pkg::PH_HDR_MAGIC && r_state.field_byte_count == 8'd1))
        else $error("start of file did not restart header parsing");

    a_chunk_count_down : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_in_data.start_of_file && r_state.phase >= mfsp_pkg::PH_DELTA &&
         r_state.phase <= mfsp_pkg::PH_NOTE_VEL) |=>
        (r_state.chunk_remaining <= $past(r_state.chunk_remaining)))
        else $error("chunk counter grew inside a track");

    a_kind_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.kind <= mfsp_pkg::KIND_ERROR))
        else $error("result kind out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/mfsp_step.sv
`default_nettype none

module mfsp_step (
    input  wire mfsp_pkg::t_state   i_state,
    input  wire mfsp_pkg::t_in_item i_item,
    output mfsp_pkg::t_state        o_state,
    output logic                    o_emit,
    output mfsp_pkg::t_out_item     o_result
);

    mfsp_pkg::t_state s;
    logic [7:0]  b;
    logic [31:0] acc_byte;
    logic [7:0]  cnt_inc;
    logic [3:0]  hi;
    logic [15:0] tl_dec;
    logic [7:0]  mr_dec;
    mfsp_pkg::t_phase trk_next;

    // closes an event; the track ends when the chunk counter is spent
    function automatic mfsp_pkg::t_state end_event(input mfsp_pkg::t_state st,
                                                   input logic [15:0] tl_m1,
                                                   input mfsp_pkg::t_phase tp);
        mfsp_pkg::t_state r;
        r = st;
        r.accumulator = 32'd0;
        if (st.chunk_remaining == 32'd0) begin
            r.field_byte_count = 8'd0;
            r.tracks_left      = tl_m1;
            r.phase            = tp;
        end else begin
            r.phase = mfsp_pkg::PH_DELTA;
        end
        return r;
    endfunction

    always_comb begin
        s = i_item.start_of_file ? mfsp_pkg::STATE_RESET : i_state;
        if (s.phase >= mfsp_pkg::PH_DELTA && s.phase <= mfsp_pkg::PH_NOTE_VEL &&
            s.chunk_remaining != 32'd0) begin
            s.chunk_remaining = s.chunk_remaining - 32'd1;
        end
    end

    assign b        = i_item.data_byte;
    assign acc_byte = {s.accumulator[23:0], b};
    assign cnt_inc  = s.field_byte_count + 8'd1;
    assign hi       = b[7:4];
    assign tl_dec   = s.tracks_left - 16'd1;
    assign mr_dec   = s.meta_remaining - 8'd1;
    assign trk_next = (tl_dec == 16'd0) ? mfsp_pkg::PH_DONE : mfsp_pkg::PH_TRK_MAGIC;

    always_comb begin
        o_state  = s;
        o_emit   = 1'b0;
        o_result = '0;
        unique case (s.phase)
            mfsp_pkg::PH_HDR_MAGIC, mfsp_pkg::PH_HDR_LEN, mfsp_pkg::PH_HDR_FORMAT,
            mfsp_pkg::PH_HDR_TRACKS, mfsp_pkg::PH_HDR_DIV, mfsp_pkg::PH_TRK_MAGIC,
            mfsp_pkg::PH_TRK_LEN: begin
                o_state.accumulator      = acc_byte;
                o_state.field_byte_count = cnt_inc;
                // magic and length fields are four bytes, header words two
                if (cnt_inc >= ((s.phase == mfsp_pkg::PH_HDR_MAGIC ||
                                 s.phase == mfsp_pkg::PH_HDR_LEN ||
                                 s.phase == mfsp_pkg::PH_TRK_MAGIC ||
                                 s.phase == mfsp_pkg::PH_TRK_LEN) ? 8'd4 : 8'd2)) begin
                    o_state.field_byte_count = 8'd0;
                    unique case (s.phase)
                        mfsp_pkg::PH_HDR_MAGIC: begin
                            o_state.phase = mfsp_pkg::PH_HDR_LEN;
                            if (acc_byte != mfsp_pkg::MAGIC_HEADER) begin
                                o_emit         = 1'b1;
                                o_result.kind  = mfsp_pkg::KIND_ERROR;
                                o_result.value = mfsp_pkg::ERR_HEADER;
                            end
                        end
                        mfsp_pkg::PH_HDR_LEN: o_state.phase = mfsp_pkg::PH_HDR_FORMAT;
                        mfsp_pkg::PH_HDR_FORMAT: o_state.phase = mfsp_pkg::PH_HDR_TRACKS;
                        mfsp_pkg::PH_HDR_TRACKS: begin
                            o_state.tracks_left = acc_byte[15:0];
                            o_state.phase       = mfsp_pkg::PH_HDR_DIV;
                        end
                        mfsp_pkg::PH_HDR_DIV: begin
                            o_state.accumulator  = 32'd0;
                            o_state.phase        = (s.tracks_left == 16'd0) ?
                                                   mfsp_pkg::PH_DONE : mfsp_pkg::PH_TRK_MAGIC;
                            o_emit               = 1'b1;
                            o_result.kind        = mfsp_pkg::KIND_HEADER;
                            o_result.value       = {16'd0, acc_byte[15:0]};
                            o_result.track_count = s.tracks_left;
                        end
                        mfsp_pkg::PH_TRK_MAGIC: begin
                            o_state.phase = mfsp_pkg::PH_TRK_LEN;
                            if (acc_byte != mfsp_pkg::MAGIC_TRACK) begin
                                o_emit         = 1'b1;
                                o_result.kind  = mfsp_pkg::KIND_ERROR;
                                o_result.value = mfsp_pkg::ERR_TRACK;
                            end
                        end
                        default: begin
                            o_state.chunk_remaining = acc_byte;
                            o_state.accumulator     = 32'd0;
                            if (acc_byte == 32'd0) begin
                                o_state.tracks_left = tl_dec;
                                o_state.phase       = trk_next;
                            end else begin
                                o_state.phase = mfsp_pkg::PH_DELTA;
                            end
                        end
                    endcase
                end
            end
            mfsp_pkg::PH_DELTA: begin
                o_state.accumulator = {s.accumulator[24:0], b[6:0]};
                if (!b[7]) begin
                    o_state.phase = mfsp_pkg::PH_STATUS;
                    if ({s.accumulator[24:0], b[6:0]} != 32'd0) begin
                        o_state.accumulator = 32'd0;
                        o_emit              = 1'b1;
                        o_result.kind       = mfsp_pkg::KIND_DELAY;
                        o_result.value      = {s.accumulator[24:0], b[6:0]};
                    end
                end
            end
            mfsp_pkg::PH_STATUS: begin
                o_state.status_byte = b;
                o_state.accumulator = 32'd0;
                if (b == mfsp_pkg::STATUS_META) begin
                    o_state.phase = mfsp_pkg::PH_META_TYPE;
                end else if (hi == mfsp_pkg::HI_NOTE_OFF || hi == mfsp_pkg::HI_NOTE_ON) begin
                    o_state.phase = mfsp_pkg::PH_NOTE_NUM;
                end else if (hi == mfsp_pkg::HI_POLY_AT || hi == mfsp_pkg::HI_CONTROL ||
                             hi == mfsp_pkg::HI_PITCH) begin
                    o_state.meta_remaining = 8'd2;
                    o_state.phase          = mfsp_pkg::PH_SKIP;
                end else if (hi == mfsp_pkg::HI_PROGRAM || hi == mfsp_pkg::HI_CHAN_AT) begin
                    o_state.meta_remaining = 8'd1;
                    o_state.phase          = mfsp_pkg::PH_SKIP;
                end else begin
                    o_state        = end_event(o_state, tl_dec, trk_next);
                    o_emit         = 1'b1;
                    o_result.kind  = mfsp_pkg::KIND_ERROR;
                    o_result.value = mfsp_pkg::ERR_EVENT;
                end
            end
            mfsp_pkg::PH_META_TYPE: begin
                o_state.meta_type = b;
                o_state.phase     = mfsp_pkg::PH_META_LEN;
            end
            mfsp_pkg::PH_META_LEN: begin
                o_state.meta_remaining = b;
                o_state.accumulator    = 32'd0;
                if (s.meta_type == mfsp_pkg::META_TEMPO) begin
                    if (b == 8'd0) begin
                        o_state        = end_event(o_state, tl_dec, trk_next);
                        o_emit         = 1'b1;
                        o_result.kind  = mfsp_pkg::KIND_TEMPO;
                        o_result.value = 32'd0;
                    end else begin
                        o_state.phase = mfsp_pkg::PH_TEMPO;
                    end
                end else if (b == 8'd0) begin
                    o_state = end_event(o_state, tl_dec, trk_next);
                end else begin
                    o_state.phase = mfsp_pkg::PH_SKIP;
                end
            end
            mfsp_pkg::PH_TEMPO: begin
                o_state.accumulator    = acc_byte;
                o_state.meta_remaining = mr_dec;
                if (mr_dec == 8'd0) begin
                    o_state        = end_event(o_state, tl_dec, trk_next);
                    o_emit         = 1'b1;
                    o_result.kind  = mfsp_pkg::KIND_TEMPO;
                    o_result.value = acc_byte;
                end
            end
            mfsp_pkg::PH_SKIP: begin
                o_state.meta_remaining = mr_dec;
                if (mr_dec == 8'd0) begin
                    o_state = end_event(o_state, tl_dec, trk_next);
                end
            end
            mfsp_pkg::PH_NOTE_NUM: begin
                o_state.first_data_byte = b;
                o_state.phase           = mfsp_pkg::PH_NOTE_VEL;
            end
            mfsp_pkg::PH_NOTE_VEL: begin
                o_state           = end_event(o_state, tl_dec, trk_next);
                o_emit            = 1'b1;
                o_result.kind     = (s.status_byte[7:4] == mfsp_pkg::HI_NOTE_ON) ?
                                    mfsp_pkg::KIND_NOTE_ON : mfsp_pkg::KIND_NOTE_OFF;
                o_result.channel  = s.status_byte[3:0];
                o_result.note     = s.first_data_byte;
                o_result.velocity = b;
            end
            default: begin
                o_state = s;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: tb/midi_file_stream_parser_tb.sv
`timescale 1ns / 1ps

module midi_file_stream_parser_tb;

    localparam int IDLE_LIMIT = 5000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    mfsp_pkg::t_in_item  in_data;
    logic                out_valid;
    logic                out_ready;
    mfsp_pkg::t_out_item out_data;

    // own copy of the parse state, updated on every accepted request
    mfsp_pkg::t_state    parser_state;
    mfsp_pkg::t_out_item expected_events[$];
    mfsp_pkg::t_out_item oldest_event;

    logic [7:0] stream_bytes[$];
    logic       stream_sofs[$];

    int  mismatch_count = 0;
    int  items_sent = 0;
    int  idle_cycles = 0;
    int  hold_off_left = 0;
    int  stall_left = 0;
    bit  steady_flow = 1'b0;

    midi_file_stream_parser DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // parse prediction
    // ------------------------------------------------------------------
    task automatic expect_event(input logic [2:0] kind, input logic [3:0] channel,
                                input logic [7:0] note, input logic [7:0] velocity,
                                input logic [31:0] value, input logic [15:0] track_count);
        mfsp_pkg::t_out_item ev;
        ev.kind        = kind;
        ev.channel     = channel;
        ev.note        = note;
        ev.velocity    = velocity;
        ev.value       = value;
        ev.track_count = track_count;
        expected_events.push_back(ev);
    endtask

    // shifts a big-endian field byte in, true once n bytes are gathered
    function automatic logic shift_in_field(input logic [7:0] b, input int n);
        parser_state.accumulator      = {parser_state.accumulator[23:0], b};
        parser_state.field_byte_count = parser_state.field_byte_count + 8'd1;
        if (parser_state.field_byte_count >= n) begin
            parser_state.field_byte_count = 8'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic close_track();
        parser_state.accumulator      = 32'd0;
        parser_state.field_byte_count = 8'd0;
        parser_state.tracks_left      = parser_state.tracks_left - 16'd1;
        if (parser_state.tracks_left == 16'd0) begin
            parser_state.phase = mfsp_pkg::PH_DONE;
        end else begin
            parser_state.phase = mfsp_pkg::PH_TRK_MAGIC;
        end
    endtask

    task automatic close_event();
        parser_state.accumulator = 32'd0;
        if (parser_state.chunk_remaining == 32'd0) begin
            close_track();
        end else begin
            parser_state.phase = mfsp_pkg::PH_DELTA;
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic sof);
        logic [3:0]  hi;
        logic [2:0]  note_kind;
        logic [31:0] held;
        if (sof) begin
            parser_state = mfsp_pkg::STATE_RESET;
        end
        if (parser_state.phase >= mfsp_pkg::PH_DELTA &&
            parser_state.phase <= mfsp_pkg::PH_NOTE_VEL &&
            parser_state.chunk_remaining != 32'd0) begin
            parser_state.chunk_remaining = parser_state.chunk_remaining - 32'd1;
        end
        case (parser_state.phase)
            mfsp_pkg::PH_HDR_MAGIC: begin
                if (shift_in_field(b, 4)) begin
                    parser_state.phase = mfsp_pkg::PH_HDR_LEN;
                    if (parser_state.accumulator != mfsp_pkg::MAGIC_HEADER) begin
                        expect_event(mfsp_pkg::KIND_ERROR, 4'd0, 8'd0, 8'd0,
                                     mfsp_pkg::ERR_HEADER, 16'd0);
                    end
                end
            end
            mfsp_pkg::PH_HDR_LEN: begin
                if (shift_in_field(b, 4)) parser_state.phase = mfsp_pkg::PH_HDR_FORMAT;
            end
            mfsp_pkg::PH_HDR_FORMAT: begin
                if (shift_in_field(b, 2)) parser_state.phase = mfsp_pkg::PH_HDR_TRACKS;
            end
            mfsp_pkg::PH_HDR_TRACKS: begin
                if (shift_in_field(b, 2)) begin
                    parser_state.tracks_left = parser_state.accumulator[15:0];
                    parser_state.phase       = mfsp_pkg::PH_HDR_DIV;
                end
            end
            mfsp_pkg::PH_HDR_DIV: begin
                if (shift_in_field(b, 2)) begin
                    held = {16'd0, parser_state.accumulator[15:0]};
                    parser_state.accumulator = 32'd0;
                    if (parser_state.tracks_left == 16'd0) begin
                        parser_state.phase = mfsp_pkg::PH_DONE;
                    end else begin
                        parser_state.phase = mfsp_pkg::PH_TRK_MAGIC;
                    end
                    expect_event(mfsp_pkg::KIND_HEADER, 4'd0, 8'd0, 8'd0, held,
                                 parser_state.tracks_left);
                end
            end
            mfsp_pkg::PH_TRK_MAGIC: begin
                if (shift_in_field(b, 4)) begin
                    parser_state.phase = mfsp_pkg::PH_TRK_LEN;
                    if (parser_state.accumulator != mfsp_pkg::MAGIC_TRACK) begin
                        expect_event(mfsp_pkg::KIND_ERROR, 4'd0, 8'd0, 8'd0,
                                     mfsp_pkg::ERR_TRACK, 16'd0);
                    end
                end
            end
            mfsp_pkg::PH_TRK_LEN: begin
                if (shift_in_field(b, 4)) begin
                    parser_state.chunk_remaining = parser_state.accumulator;
                    parser_state.accumulator     = 32'd0;
                    if (parser_state.chunk_remaining == 32'd0) begin
                        close_track();
                    end else begin
                        parser_state.phase = mfsp_pkg::PH_DELTA;
                    end
                end
            end
            mfsp_pkg::PH_DELTA: begin
                parser_state.accumulator = (parser_state.accumulator << 7) + {25'd0, b[6:0]};
                if (!b[7]) begin
                    parser_state.phase = mfsp_pkg::PH_STATUS;
                    if (parser_state.accumulator != 32'd0) begin
                        held = parser_state.accumulator;
                        parser_state.accumulator = 32'd0;
                        expect_event(mfsp_pkg::KIND_DELAY, 4'd0, 8'd0, 8'd0, held, 16'd0);
                    end
                end
            end
            mfsp_pkg::PH_STATUS: begin
                parser_state.status_byte = b;
                parser_state.accumulator = 32'd0;
                hi = b[7:4];
                if (b == mfsp_pkg::STATUS_META) begin
                    parser_state.phase = mfsp_pkg::PH_META_TYPE;
                end else if (hi == mfsp_pkg::HI_NOTE_OFF || hi == mfsp_pkg::HI_NOTE_ON) begin
                    parser_state.phase = mfsp_pkg::PH_NOTE_NUM;
                end else if (hi == mfsp_pkg::HI_POLY_AT || hi == mfsp_pkg::HI_CONTROL ||
                             hi == mfsp_pkg::HI_PITCH) begin
                    parser_state.meta_remaining = 8'd2;
                    parser_state.phase          = mfsp_pkg::PH_SKIP;
                end else if (hi == mfsp_pkg::HI_PROGRAM || hi == mfsp_pkg::HI_CHAN_AT) begin
                    parser_state.meta_remaining = 8'd1;
                    parser_state.phase          = mfsp_pkg::PH_SKIP;
                end else begin
                    close_event();
                    expect_event(mfsp_pkg::KIND_ERROR, 4'd0, 8'd0, 8'd0,
                                 mfsp_pkg::ERR_EVENT, 16'd0);
                end
            end
            mfsp_pkg::PH_META_TYPE: begin
                parser_state.meta_type = b;
                parser_state.phase     = mfsp_pkg::PH_META_LEN;
            end
            mfsp_pkg::PH_META_LEN: begin
                parser_state.meta_remaining = b;
                parser_state.accumulator    = 32'd0;
                if (parser_state.meta_type == mfsp_pkg::META_TEMPO) begin
                    if (b == 8'd0) begin
                        close_event();
                        expect_event(mfsp_pkg::KIND_TEMPO, 4'd0, 8'd0, 8'd0, 32'd0, 16'd0);
                    end else begin
                        parser_state.phase = mfsp_pkg::PH_TEMPO;
                    end
                end else if (b == 8'd0) begin
                    close_event();
                end else begin
                    parser_state.phase = mfsp_pkg::PH_SKIP;
                end
            end
            mfsp_pkg::PH_TEMPO: begin
                parser_state.accumulator    = {parser_state.accumulator[23:0], b};
                parser_state.meta_remaining = parser_state.meta_remaining - 8'd1;
                if (parser_state.meta_remaining == 8'd0) begin
                    held = parser_state.accumulator;
                    close_event();
                    expect_event(mfsp_pkg::KIND_TEMPO, 4'd0, 8'd0, 8'd0, held, 16'd0);
                end
            end
            mfsp_pkg::PH_SKIP: begin
                parser_state.meta_remaining = parser_state.meta_remaining - 8'd1;
                if (parser_state.meta_remaining == 8'd0) close_event();
            end
            mfsp_pkg::PH_NOTE_NUM: begin
                parser_state.first_data_byte = b;
                parser_state.phase           = mfsp_pkg::PH_NOTE_VEL;
            end
            mfsp_pkg::PH_NOTE_VEL: begin
                close_event();
                if (parser_state.status_byte[7:4] == mfsp_pkg::HI_NOTE_ON) begin
                    note_kind = mfsp_pkg::KIND_NOTE_ON;
                end else begin
                    note_kind = mfsp_pkg::KIND_NOTE_OFF;
                end
                expect_event(note_kind, parser_state.status_byte[3:0],
                             parser_state.first_data_byte, b, 32'd0, 16'd0);
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // file building
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic sof);
        stream_bytes.push_back(b);
        stream_sofs.push_back(sof);
    endtask

    task automatic put_word(input logic [31:0] w, input int n);
        for (int i = n - 1; i >= 0; i--) put_byte(w[8*i +: 8], 1'b0);
    endtask

    task automatic put_delta(input logic [31:0] ticks);
        logic [6:0]  groups[$];
        logic [31:0] rest;
        logic        more;
        rest = ticks;
        groups.push_front(rest[6:0]);
        rest = rest >> 7;
        while (rest != 32'd0) begin
            groups.push_front(rest[6:0]);
            rest = rest >> 7;
        end
        foreach (groups[i]) begin
            more = (i != groups.size() - 1);
            put_byte({more, groups[i]}, 1'b0);
        end
    endtask

    task automatic put_header(input logic [31:0] magic, input logic [31:0] hdr_len,
                              input logic [15:0] format, input logic [15:0] tracks,
                              input logic [15:0] division);
        put_byte(magic[31:24], 1'b1);
        put_word(magic, 3);
        put_word(hdr_len, 4);
        put_word({16'd0, format}, 2);
        put_word({16'd0, tracks}, 2);
        put_word({16'd0, division}, 2);
    endtask

    // length is patched in once the body is known
    task automatic put_track_start(input logic [31:0] magic, output int len_pos);
        put_word(magic, 4);
        len_pos = stream_bytes.size();
        put_word(32'd0, 4);
    endtask

    task automatic set_track_length(input int len_pos, input logic [31:0] len);
        for (int k = 0; k < 4; k++) stream_bytes[len_pos + k] = len[8*(3-k) +: 8];
    endtask

    task automatic put_random_file();
        logic [31:0] magic;
        logic [31:0] len;
        logic [7:0]  status;
        int          track_total;
        int          event_total;
        int          len_pos;
        int          body;
        int          r;
        int          n;
        magic = mfsp_pkg::MAGIC_HEADER;
        if ($urandom_range(0, 9) == 0) magic = magic ^ (32'd1 << $urandom_range(0, 31));
        track_total = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        put_header(magic, $urandom(), 16'($urandom_range(0, 16'hFFFF)), 16'(track_total),
                   16'($urandom_range(0, 16'hFFFF)));
        for (int t = 0; t < track_total; t++) begin
            magic = mfsp_pkg::MAGIC_TRACK;
            if ($urandom_range(0, 11) == 0) magic = magic ^ (32'd1 << $urandom_range(0, 31));
            put_track_start(magic, len_pos);
            event_total = $urandom_range(1, 10);
            for (int e = 0; e < event_total; e++) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    put_byte(8'h00, 1'b0);
                end else if (r < 75) begin
                    put_delta($urandom_range(1, 127));
                end else if (r < 92) begin
                    put_delta($urandom_range(128, 32'h001F_FFFF));
                end else if (r < 96) begin
                    put_delta($urandom());
                end else begin
                    // delta longer than the accumulator holds
                    n = $urandom_range(5, 7);
                    repeat (n - 1) put_byte(rand_byte() | 8'h80, 1'b0);
                    put_byte(rand_byte() & 8'h7F, 1'b0);
                end
                r = $urandom_range(0, 99);
                status = rand_byte();
                if (r < 45) begin
                    status[7:4] = (r < 25) ? mfsp_pkg::HI_NOTE_ON : mfsp_pkg::HI_NOTE_OFF;
                    put_byte(status, 1'b0);
                    put_byte(rand_byte(), 1'b0);
                    put_byte(rand_byte(), 1'b0);
                end else if (r < 58) begin
                    case ($urandom_range(0, 2))
                        0: status[7:4] = mfsp_pkg::HI_POLY_AT;
                        1: status[7:4] = mfsp_pkg::HI_CONTROL;
                        default: status[7:4] = mfsp_pkg::HI_PITCH;
                    endcase
                    put_byte(status, 1'b0);
                    put_byte(rand_byte(), 1'b0);
                    put_byte(rand_byte(), 1'b0);
                end else if (r < 66) begin
                    status[7:4] = ($urandom_range(0, 1) == 0) ?
                                  mfsp_pkg::HI_PROGRAM : mfsp_pkg::HI_CHAN_AT;
                    put_byte(status, 1'b0);
                    put_byte(rand_byte(), 1'b0);
                end else if (r < 88) begin
                    put_byte(mfsp_pkg::STATUS_META, 1'b0);
                    if (r < 78) begin
                        put_byte(mfsp_pkg::META_TEMPO, 1'b0);
                        n = ($urandom_range(0, 3) != 0) ? 3 : $urandom_range(0, 6);
                    end else begin
                        put_byte(rand_byte(), 1'b0);
                        n = $urandom_range(0, 5);
                    end
                    put_byte(8'(n), 1'b0);
                    repeat (n) put_byte(rand_byte(), 1'b0);
                end else begin
                    // status the parser does not know
                    if ($urandom_range(0, 1) == 0) begin
                        status = 8'($urandom_range(0, 8'h7F));
                    end else begin
                        status = 8'($urandom_range(8'hF0, 8'hFE));
                    end
                    put_byte(status, 1'b0);
                end
            end
            body = stream_bytes.size() - len_pos - 4;
            r = $urandom_range(0, 99);
            if (r < 85) begin
                len = body;
            end else if (r < 93) begin
                len = $urandom_range(0, body - 1);
            end else begin
                len = body + $urandom_range(1, 6);
            end
            set_track_length(len_pos, len);
        end
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) put_byte(rand_byte(), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic sof);
        int gap;
        gap = steady_flow ? 0 : idle_length();
        @(negedge clk);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid              = 1'b1;
        in_data.data_byte     = b;
        in_data.start_of_file = sof;
        // hold the request until it is taken
        do @(posedge clk); while (!in_ready);
        predict_byte(b, sof);
        items_sent++;
    endtask

    task automatic send_stream();
        foreach (stream_bytes[i]) send_byte(stream_bytes[i], stream_sofs[i]);
        stream_bytes.delete();
        stream_sofs.delete();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_results_drained();
        while (expected_events.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_left != 0) begin
                out_ready = 1'b0;
                hold_off_left--;
            end else if (stall_left != 0) begin
                out_ready = 1'b0;
                stall_left--;
            end else begin
                out_ready = 1'b1;
                if (!steady_flow && $urandom_range(0, 2) == 0) stall_left = idle_length();
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_events.size() == 0) begin
                $error("result with none expected: kind %0d value 0x%0h",
                       out_data.kind, out_data.value);
                mismatch_count++;
            end else begin
                oldest_event = expected_events.pop_front();
                check_field("kind", 32'(oldest_event.kind), 32'(out_data.kind));
                check_field("channel", 32'(oldest_event.channel), 32'(out_data.channel));
                check_field("note", 32'(oldest_event.note), 32'(out_data.note));
                check_field("velocity", 32'(oldest_event.velocity), 32'(out_data.velocity));
                check_field("value", oldest_event.value, out_data.value);
                check_field("track_count", 32'(oldest_event.track_count),
                            32'(out_data.track_count));
            end
        end
    end

    // ends the run if nothing moves on either side for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("midi_file_stream_parser: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_header_fields();
        // bad magic, then the header still parses with extreme fields
        put_header(mfsp_pkg::MAGIC_HEADER ^ 32'h0000_0001, 32'd6, 16'd1, 16'hFFFF, 16'h0000);
        send_stream();
        // no tracks: following bytes are ignored
        put_header(mfsp_pkg::MAGIC_HEADER, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        send_stream();
        wait_results_drained();
    endtask

    task automatic test_track_events();
        int len_pos;
        put_header(mfsp_pkg::MAGIC_HEADER, 32'd6, 16'd1, 16'd2, 16'h01E0);
        put_track_start(mfsp_pkg::MAGIC_TRACK ^ 32'h0000_0100, len_pos);
        put_byte(8'h00, 1'b0);
        put_byte({mfsp_pkg::HI_NOTE_ON, 4'h0}, 1'b0);
        put_byte(8'h3C, 1'b0);
        put_byte(8'h7F, 1'b0);
        put_delta(32'd128);
        put_byte({mfsp_pkg::HI_NOTE_OFF, 4'hF}, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        // over-long delta keeps its low 32 bits
        repeat (4) put_byte(8'hFF, 1'b0);
        put_byte(8'h7F, 1'b0);
        put_byte(mfsp_pkg::STATUS_META, 1'b0);
        put_byte(mfsp_pkg::META_TEMPO, 1'b0);
        put_word(32'h0307_A120, 4);
        // zero-length tempo
        put_byte(8'h00, 1'b0);
        put_byte(mfsp_pkg::STATUS_META, 1'b0);
        put_byte(mfsp_pkg::META_TEMPO, 1'b0);
        put_byte(8'h00, 1'b0);
        // unknown status bytes, each followed straight by a delta
        put_byte(8'h00, 1'b0);
        put_byte(8'hF5, 1'b0);
        put_delta(32'h0FFF_FFFF);
        put_byte(8'h7F, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte({mfsp_pkg::HI_PROGRAM, 4'h3}, 1'b0);
        put_byte(8'h12, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte({mfsp_pkg::HI_CONTROL, 4'h0}, 1'b0);
        put_byte(8'h07, 1'b0);
        put_byte(8'h64, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(mfsp_pkg::STATUS_META, 1'b0);
        put_word(32'h0102_4142, 4);
        put_byte(8'h00, 1'b0);
        put_byte(mfsp_pkg::STATUS_META, 1'b0);
        put_byte(8'h2F, 1'b0);
        put_byte(8'h00, 1'b0);
        set_track_length(len_pos, stream_bytes.size() - len_pos - 4);
        // empty track closes the file
        put_track_start(mfsp_pkg::MAGIC_TRACK, len_pos);
        put_byte(8'h90, 1'b0);
        put_byte(8'h11, 1'b0);
        send_stream();
        wait_results_drained();
    endtask

    task automatic test_chunk_overrun();
        int len_pos;
        put_header(mfsp_pkg::MAGIC_HEADER, 32'd6, 16'd0, 16'd1, 16'd96);
        put_track_start(mfsp_pkg::MAGIC_TRACK, len_pos);
        put_byte(8'h00, 1'b0);
        put_byte({mfsp_pkg::HI_NOTE_ON, 4'h5}, 1'b0);
        put_byte(8'h40, 1'b0);
        put_byte(8'h40, 1'b0);
        set_track_length(len_pos, 32'd2);
        put_byte(8'h00, 1'b0);
        put_byte(8'h90, 1'b0);
        send_stream();
        wait_results_drained();
    endtask

    task automatic test_output_hold_off();
        // results back up, the input stalls while requests keep coming
        hold_off_left = 400;
        put_random_file();
        put_random_file();
        send_stream();
        wait_results_drained();
    endtask

    task automatic test_back_to_back();
        steady_flow = 1'b1;
        put_random_file();
        put_random_file();
        send_stream();
        wait_results_drained();
        steady_flow = 1'b0;
    endtask

    task automatic test_random_files();
        int stop_at;
        int n;
        stop_at = items_sent + 700;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise with the odd restart in it
                n = $urandom_range(1, 16);
                repeat (n) put_byte(rand_byte(), $urandom_range(0, 7) == 0);
            end else begin
                put_random_file();
            end
            send_stream();
            if ($urandom_range(0, 7) == 0) wait_results_drained();
        end
        wait_results_drained();
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        parser_state = mfsp_pkg::STATE_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_header_fields();
        test_track_events();
        test_chunk_overrun();
        test_output_hold_off();
        test_back_to_back();
        test_random_files();

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_events.size() == 0) begin
            $display("midi_file_stream_parser: match");
        end else begin
            $display("midi_file_stream_parser: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/mfsp_pkg.sv
rtl/core/mfsp_step.sv
rtl/core/midi_file_stream_parser.sv
tb/midi_file_stream_parser_tb.sv
